### rtl/core/u8u_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
package u8u_pkg;

	localparam int unsigned CODE_W    = 16;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY     = 1'b1;

	localparam logic [CODE_W-1:0] MAX_OUT_LENGTH_RST = 16'd256;
	localparam logic [CODE_W-1:0] COUNT_MAX          = 16'hFFFF;

	// Lead byte classification and payload masks.
	localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MATCH = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_MATCH = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
	localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// One decoded event handed from the front to the back.
	typedef struct packed {
		logic              is_end;   // terminating zero byte
		logic              has_char; // a character completes with this event
		logic [CODE_W-1:0] code;
	} evt_t;

endpackage

### rtl/core/u8u_if.sv
// Channel interfaces for the byte input and the code unit output.
interface u8u_in_if;
	logic                        valid;
	logic                        ready;
	logic [u8u_pkg::BYTE_W-1:0]  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u_out_if;
	logic                        valid;
	logic                        ready;
	logic                        code_valid;
	logic [u8u_pkg::CODE_W-1:0]  code_unit;
	logic                        end_of_string;
	logic [u8u_pkg::CODE_W-1:0]  char_count;

	modport source (output valid, output code_valid, output code_unit,
		output end_of_string, output char_count, input ready);
	modport sink   (input valid, input code_valid, input code_unit,
		input end_of_string, input char_count, output ready);
endinterface

### rtl/core/u8u_front.sv
// Front end: accepts bytes, assembles multi-byte sequences, and emits events.
module u8u_front (
	input  logic            clk,
	input  logic            arst_n,
	u8u_in_if.sink          bytes,
	input  logic            q_full,
	output logic            push,
	output u8u_pkg::evt_t   evt
);

	logic [1:0]                   pend_q, pend_d;
	logic [u8u_pkg::CODE_W-1:0]   accum_q, accum_d;
	logic [u8u_pkg::BYTE_W-1:0]   b;
	logic [u8u_pkg::CODE_W-1:0]   cont_bits;
	logic [u8u_pkg::CODE_W-1:0]   merged;
	logic                         take;

	assign bytes.ready = !q_full;
	assign take        = bytes.valid && bytes.ready;
	assign b           = bytes.in_byte;

	// The first following byte of a three-byte form lands at bit 6, the last at bit 0.
	always_comb begin
		cont_bits = {{(u8u_pkg::CODE_W-u8u_pkg::BYTE_W){1'b0}}, b & u8u_pkg::CONT_BITS};
		if (pend_q == u8u_pkg::PEND_TWO) begin
			merged = accum_q | (cont_bits << 6);
		end else begin
			merged = accum_q | cont_bits;
		end
	end

	always_comb begin
		push         = 1'b0;
		evt.is_end   = 1'b0;
		evt.has_char = 1'b0;
		evt.code     = '0;
		pend_d       = pend_q;
		accum_d      = accum_q;
		if (take) begin
			if (b == '0) begin
				push         = 1'b1;
				evt.is_end   = 1'b1;
				evt.has_char = (pend_q != u8u_pkg::PEND_NONE);
				evt.code     = accum_q;
				pend_d       = u8u_pkg::PEND_NONE;
				accum_d      = '0;
			end else if (pend_q != u8u_pkg::PEND_NONE) begin
				pend_d = pend_q - 2'd1;
				if (pend_q == u8u_pkg::PEND_ONE) begin
					push         = 1'b1;
					evt.has_char = 1'b1;
					evt.code     = merged;
					accum_d      = '0;
				end else begin
					accum_d = merged;
				end
			end else if ((b & u8u_pkg::LEAD2_MASK) == u8u_pkg::LEAD2_MATCH) begin
				accum_d = {5'b0, b[4:0] & u8u_pkg::LEAD2_BITS[4:0], 6'b0};
				pend_d  = u8u_pkg::PEND_ONE;
			end else if ((b & u8u_pkg::LEAD3_MASK) == u8u_pkg::LEAD3_MATCH) begin
				accum_d = {b[3:0] & u8u_pkg::LEAD3_BITS[3:0], 12'b0};
				pend_d  = u8u_pkg::PEND_TWO;
			end else begin
				push         = 1'b1;
				evt.has_char = 1'b1;
				evt.code     = {{(u8u_pkg::CODE_W-u8u_pkg::BYTE_W){1'b0}}, b};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= u8u_pkg::PEND_NONE;
			accum_q <= '0;
		end else begin
			pend_q  <= pend_d;
			accum_q <= accum_d;
		end
	end

endmodule

### rtl/core/u8u_queue.sv
// Small event queue between the front end and the back end.
module u8u_queue #(
	parameter int unsigned DEPTH = u8u_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u8u_pkg::evt_t   push_evt,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output u8u_pkg::evt_t   head_evt
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	u8u_pkg::evt_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_evt   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/u8u_back.sv
// Back end: counts characters against the limit and drives the result register.
module u8u_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [u8u_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [u8u_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	input  logic                            head_valid,
	input  u8u_pkg::evt_t                   head_evt,
	output logic                            pop,
	u8u_out_if.source                       codes
);

	logic [u8u_pkg::CODE_W-1:0] limit_q;
	logic                       count_only_q;
	logic [u8u_pkg::CODE_W-1:0] seen_q;

	logic                       out_valid_q;
	logic                       code_valid_q;
	logic [u8u_pkg::CODE_W-1:0] code_unit_q;
	logic                       eos_q;
	logic [u8u_pkg::CODE_W-1:0] count_q;

	logic [u8u_pkg::CODE_W-1:0] lim;
	logic [u8u_pkg::CODE_W-1:0] seen_new;
	logic [u8u_pkg::CODE_W-1:0] reported;
	logic                       emit;
	logic                       result;

	assign pop = head_valid && (!out_valid_q || codes.ready);

	assign lim = (limit_q == '0) ? '0 : limit_q - 1'b1;

	always_comb begin
		seen_new = seen_q;
		emit     = 1'b0;
		if (head_evt.has_char) begin
			if (count_only_q) begin
				if (seen_q != u8u_pkg::COUNT_MAX) begin
					seen_new = seen_q + 1'b1;
				end
			end else if (seen_q < lim) begin
				seen_new = seen_q + 1'b1;
				emit     = 1'b1;
			end
		end
		// A count run up in count-only mode still reports capped after a switch to write mode.
		reported = (!count_only_q && seen_new > lim) ? lim : seen_new;
		result   = head_evt.is_end || emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= u8u_pkg::MAX_OUT_LENGTH_RST;
			count_only_q <= 1'b0;
			seen_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					u8u_pkg::REG_MAX_OUT_LENGTH: limit_q      <= cfg_wdata;
					u8u_pkg::REG_COUNT_ONLY:     count_only_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (pop) begin
				seen_q <= head_evt.is_end ? '0 : seen_new;
			end
			if (pop && result) begin
				out_valid_q <= 1'b1;
			end else if (codes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && result) begin
			code_valid_q <= emit;
			code_unit_q  <= emit ? head_evt.code : '0;
			eos_q        <= head_evt.is_end;
			count_q      <= reported;
		end
	end

	assign codes.valid         = out_valid_q;
	assign codes.code_valid    = code_valid_q;
	assign codes.code_unit     = code_unit_q;
	assign codes.end_of_string = eos_q;
	assign codes.char_count    = count_q;

endmodule

### rtl/core/utf8_to_ucs2_decoder.sv
// UTF-8 to UCS-2 decoder top level.
// Takes one byte per cycle and, with the output taken every cycle, sustains one byte per
// cycle indefinitely. The front end updates the pending-byte count and the assembled code
// each cycle and posts one event per completed character or terminating zero; the back end
// applies the output limit and the count and loads the result register. A request travels
// through two registers (queue, result register): the event is written into the queue at
// the edge that accepts its byte, and the result register is loaded with a request when the
// back end pops that event. The queue of QUEUE_DEPTH events lets either side stall alone;
// the input stalls only when it is full. Lead bytes and non-final following bytes produce
// no request on the output.
module utf8_to_ucs2_decoder #(
	parameter int unsigned QUEUE_DEPTH = u8u_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [u8u_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [u8u_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	u8u_in_if.sink                          bytes,
	u8u_out_if.source                       codes
);

	logic           q_full;
	logic           push;
	u8u_pkg::evt_t  push_evt;
	logic           pop;
	logic           head_valid;
	u8u_pkg::evt_t  head_evt;

	u8u_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.q_full (q_full),
		.push   (push),
		.evt    (push_evt)
	);

	u8u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_evt   (push_evt),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_evt   (head_evt)
	);

	u8u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head_evt   (head_evt),
		.pop        (pop),
		.codes      (codes)
	);

endmodule

### rtl/core/u8u_checker.sv
// Port-level checks on the decoder output, bound to the top level.
module u8u_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          code_valid,
	input  logic [u8u_pkg::CODE_W-1:0]    code_unit,
	input  logic                          end_of_string,
	input  logic [u8u_pkg::CODE_W-1:0]    char_count
);

	// A stalled request keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit)
			&& $stable(char_count) && $stable(end_of_string))
		else $error("output request changed while stalled");

	// Only an end-of-string request may carry no character.
	a_char_or_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_string |-> code_valid)
		else $error("request without character or end of string");

	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !code_valid |-> code_unit == '0)
		else $error("code unit nonzero without a character");

	// An emitted character has been counted, so the count cannot be zero.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_valid |-> char_count != '0)
		else $error("emitted character with zero count");

endmodule

bind utf8_to_ucs2_decoder u8u_checker u_u8u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (codes.valid),
	.out_ready     (codes.ready),
	.code_valid    (codes.code_valid),
	.code_unit     (codes.code_unit),
	.end_of_string (codes.end_of_string),
	.char_count    (codes.char_count)
);
